### rtl/core/encoder_multiturn_tracker_top_macros.svh
// ----------------------------------------------------------------------------
// encoder multi-turn tracker assertion macros
// concurrent checks that fall away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ENCODER_MULTITURN_TRACKER_TOP_MACROS_SVH
`define ENCODER_MULTITURN_TRACKER_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define EMT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("encoder tracker check failed");
// next-cycle implication
`define EMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("encoder tracker check failed");
`else
`define EMT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define EMT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/core/emt_pkg.sv
// ----------------------------------------------------------------------------
// emt_pkg
// shared widths, codes and divider handshake types of the encoder tracker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package emt_pkg;

   // field widths
   localparam int ValueWidth  = 17;
   localparam int CptWidth    = 17;
   localparam int AccWidth    = 32;
   localparam int PosOutWidth = 16;
   localparam int CsrIdxWidth = 1;

   // register reset value and minimum turn size
   localparam logic [CptWidth-1:0] CptReset = CptWidth'(8192);
   localparam logic [CptWidth-1:0] MinTurn  = CptWidth'(2);

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CsrIdxMode = 1'b0;
   localparam logic [CsrIdxWidth-1:0] CsrIdxCpt  = 1'b1;

   // request kinds
   localparam logic KindSample = 1'b0;
   localparam logic KindPreset = 1'b1;

   // encoder modes
   localparam logic ModeAbsolute    = 1'b0;
   localparam logic ModeIncremental = 1'b1;

   // divider command
   typedef struct packed {
      logic                start;
      logic [AccWidth-1:0] dividend;
      logic [CptWidth-1:0] divisor;
   } div_cmd_type;

   // divider status
   typedef struct packed {
      logic                busy;
      logic                done;
      logic [AccWidth-1:0] quotient;
      logic [CptWidth-1:0] remainder;
   } div_stat_type;

endpackage

`default_nettype wire

### rtl/core/emt_if.sv
// ----------------------------------------------------------------------------
// emt request and response channels
// valid/ready channels carrying encoder requests and tracker results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface emt_req_if import emt_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic signed [ValueWidth-1:0] angle_value;

   modport source (output valid, output kind, output angle_value, input ready);
   modport sink   (input valid, input kind, input angle_value, output ready);
endinterface

interface emt_rsp_if import emt_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [PosOutWidth-1:0]       position;
   logic signed [AccWidth-1:0]   total_angle;
   logic signed [ValueWidth-1:0] last_step;
   logic signed [AccWidth-1:0]   turn_count;

   modport source (output valid, output position, output total_angle,
                   output last_step, output turn_count, input ready);
   modport sink   (input valid, input position, input total_angle,
                   input last_step, input turn_count, output ready);
endinterface

`default_nettype wire

### rtl/core/encoder_multiturn_tracker_top.sv
// ----------------------------------------------------------------------------
// encoder_multiturn_tracker_top
// multi-turn rotary encoder tracker: absolute unwrap or incremental floored
// division of the accumulated angle into position and turn count
// ----------------------------------------------------------------------------
//  channel   direction  handshake     payload
//  req_chan  in         valid/ready   kind, angle_value
//  rsp_chan  out        valid/ready   position, total_angle, last_step,
//                                     turn_count
//  csr_*     in         write enable  csr_index, csr_wdata
//
// one request at a time; a preset goes straight to StOut, an absolute sample
// through StAbsDiff, StAbsWrap and StAbsAcc, an incremental one through StIncAcc,
// StIncMag, the 32 single-bit steps of the serial divider and StIncFix.
// reset is synchronous; all tracking state clears to zero, turn size to 8192.
// the next request is taken while a result waits in the output register; a
// stalled response only holds the sequencer at its final step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "encoder_multiturn_tracker_top_macros.svh"

module encoder_multiturn_tracker_top import emt_pkg::*; #(
   parameter int POSITION_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [CptWidth-1:0]    csr_wdata,
   emt_req_if.sink                     req_chan,
   emt_rsp_if.source                   rsp_chan
);

   localparam int DiffWidth = POSITION_BITS + 2;
   localparam int MaxTurnInt = (POSITION_BITS >= CptWidth) ?
                               ((1 << CptWidth) - 1) : (1 << POSITION_BITS);
   localparam logic [CptWidth:0] MaxTurn = (CptWidth + 1)'(MaxTurnInt);

   typedef enum logic [3:0] {
      StIdle,
      StAbsDiff,
      StAbsWrap,
      StAbsAcc,
      StIncAcc,
      StIncMag,
      StIncDiv,
      StIncFix,
      StOut
   } state_type;

   state_type                     state_ff, state_in;

   // configuration
   logic                          mode_ff, mode_in;
   logic [CptWidth-1:0]           cpt_ff, cpt_in;

   // tracking state
   logic [POSITION_BITS-1:0]      last_pos_ff, last_pos_in;
   logic [AccWidth-1:0]           acc_ff, acc_in;
   logic [ValueWidth-1:0]         step_ff, step_in;
   logic [AccWidth-1:0]           turns_ff, turns_in;

   // working registers
   logic [ValueWidth-1:0]         value_ff, value_in;
   logic [CptWidth-1:0]           tsize_ff, tsize_in;
   logic signed [DiffWidth-1:0]   diff_ff, diff_in;
   logic                          neg_ff, neg_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [PosOutWidth-1:0]        pos_out_ff, pos_out_in;
   logic [AccWidth-1:0]           total_out_ff, total_out_in;
   logic [ValueWidth-1:0]         step_out_ff, step_out_in;
   logic [AccWidth-1:0]           turn_out_ff, turn_out_in;

   logic [ValueWidth-1:0]         req_raw;
   logic                          req_fire;
   logic                          preset_abs;
   logic [POSITION_BITS-1:0]      preset_pos;
   logic                          rsp_stall;
   logic                          rsp_free;
   logic [CptWidth-1:0]           tsize_now;
   logic [POSITION_BITS-1:0]      pos_abs;
   logic signed [DiffWidth-1:0]   half_s;
   logic signed [DiffWidth-1:0]   tsize_s;
   logic signed [AccWidth-1:0]    diff_ext;
   logic [AccWidth-1:0]           acc_mag;
   logic [CptWidth-1:0]           pos_fix;

   div_cmd_type                   div_cmd;
   div_stat_type                  div_stat;

   // handshake
   assign req_raw        = req_chan.angle_value;
   assign req_chan.ready = (state_ff == StIdle);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_stall      = rsp_valid_ff && !rsp_chan.ready;
   assign rsp_free       = !rsp_stall;

   // preset of the last position, absolute mode only
   assign preset_abs = req_fire && (req_chan.kind == KindPreset) && (mode_ff == ModeAbsolute);
   assign preset_pos = POSITION_BITS'(req_raw);

   // turn size clamped to the legal range
   always_comb begin
      if (cpt_ff < MinTurn) begin
         tsize_now = MinTurn;
      end else if ({1'b0, cpt_ff} > MaxTurn) begin
         tsize_now = MaxTurn[CptWidth-1:0];
      end else begin
         tsize_now = cpt_ff;
      end
   end

   // absolute path operands
   assign pos_abs  = POSITION_BITS'(value_ff);
   assign half_s   = signed'(DiffWidth'(tsize_ff >> 1));
   assign tsize_s  = signed'(DiffWidth'(tsize_ff));
   assign diff_ext = AccWidth'(diff_ff);

   // magnitude of the accumulated angle for the divider
   assign acc_mag = acc_ff[AccWidth-1] ? (~acc_ff + 1'b1) : acc_ff;

   // floored remainder from the magnitude remainder
   assign pos_fix = (neg_ff && (div_stat.remainder != '0)) ?
                    (tsize_ff - div_stat.remainder) : div_stat.remainder;

   // divider
   assign div_cmd.start    = (state_ff == StIncMag);
   assign div_cmd.dividend = acc_mag;
   assign div_cmd.divisor  = tsize_ff;

   emt_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      cpt_in       = cpt_ff;
      last_pos_in  = last_pos_ff;
      acc_in       = acc_ff;
      step_in      = step_ff;
      turns_in     = turns_ff;
      value_in     = value_ff;
      tsize_in     = tsize_ff;
      diff_in      = diff_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      pos_out_in   = pos_out_ff;
      total_out_in = total_out_ff;
      step_out_in  = step_out_ff;
      turn_out_in  = turn_out_ff;

      // response taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // register writes
      if (csr_we) begin
         case (csr_index)
            CsrIdxMode: mode_in = csr_wdata[0];
            CsrIdxCpt:  cpt_in  = csr_wdata;
            default:    cpt_in  = cpt_ff;
         endcase
      end

      case (state_ff)
         StIdle: begin
            if (req_fire) begin
               value_in = req_raw;
               tsize_in = tsize_now;
               if (req_chan.kind == KindPreset) begin
                  if (preset_abs) begin
                     last_pos_in = preset_pos;
                  end
                  state_in = StOut;
               end else if (mode_ff == ModeAbsolute) begin
                  state_in = StAbsDiff;
               end else begin
                  state_in = StIncAcc;
               end
            end
         end
         // raw difference from the last position
         StAbsDiff: begin
            diff_in  = signed'(DiffWidth'(pos_abs)) - signed'(DiffWidth'(last_pos_ff));
            state_in = StAbsWrap;
         end
         // wrap by one turn past half a turn
         StAbsWrap: begin
            if (diff_ff > half_s) begin
               diff_in  = diff_ff - tsize_s;
               turns_in = turns_ff - 1'b1;
            end else if (diff_ff < -half_s) begin
               diff_in  = diff_ff + tsize_s;
               turns_in = turns_ff + 1'b1;
            end
            state_in = StAbsAcc;
         end
         StAbsAcc: begin
            acc_in      = acc_ff + diff_ext;
            step_in     = diff_ext[ValueWidth-1:0];
            last_pos_in = pos_abs;
            state_in    = StOut;
         end
         // incremental step into the accumulator
         StIncAcc: begin
            acc_in   = acc_ff + {{(AccWidth - ValueWidth){value_ff[ValueWidth-1]}},
                                 value_ff};
            step_in  = value_ff;
            state_in = StIncMag;
         end
         StIncMag: begin
            neg_in   = acc_ff[AccWidth-1];
            state_in = StIncDiv;
         end
         StIncDiv: begin
            if (div_stat.done) begin
               state_in = StIncFix;
            end
         end
         // floored quotient and remainder
         StIncFix: begin
            if (!neg_ff) begin
               turns_in = div_stat.quotient;
            end else if (div_stat.remainder == '0) begin
               turns_in = ~div_stat.quotient + 1'b1;
            end else begin
               turns_in = ~div_stat.quotient;
            end
            last_pos_in = POSITION_BITS'(pos_fix);
            state_in    = StOut;
         end
         // load the response register once it is free
         StOut: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               pos_out_in   = PosOutWidth'(last_pos_ff);
               total_out_in = acc_ff;
               step_out_in  = step_ff;
               turn_out_in  = turns_ff;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         mode_ff      <= ModeAbsolute;
         cpt_ff       <= CptReset;
         last_pos_ff  <= '0;
         acc_ff       <= '0;
         step_ff      <= '0;
         turns_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         cpt_ff       <= cpt_in;
         last_pos_ff  <= last_pos_in;
         acc_ff       <= acc_in;
         step_ff      <= step_in;
         turns_ff     <= turns_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff     <= value_in;
      tsize_ff     <= tsize_in;
      diff_ff      <= diff_in;
      neg_ff       <= neg_in;
      pos_out_ff   <= pos_out_in;
      total_out_ff <= total_out_in;
      step_out_ff  <= step_out_in;
      turn_out_ff  <= turn_out_in;
   end

   // response outputs
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.position    = pos_out_ff;
   assign rsp_chan.total_angle = total_out_ff;
   assign rsp_chan.last_step   = step_out_ff;
   assign rsp_chan.turn_count  = turn_out_ff;

   // checks
   `EMT_ASSERT_IMPLY(a_div_start_idle, clock, reset, div_cmd.start, !div_stat.busy)
   `EMT_ASSERT_IMPLY(a_div_done_waited, clock, reset, div_stat.done, state_ff == StIncDiv)
   `EMT_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_stall, rsp_valid_ff && $stable(total_out_ff))
   `EMT_ASSERT_NEXT(a_preset_loads, clock, reset, preset_abs, last_pos_ff == $past(preset_pos))

endmodule

`default_nettype wire

### rtl/core/emt_divider.sv
// ----------------------------------------------------------------------------
// emt_divider
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module emt_divider import emt_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire div_cmd_type  cmd,
   output div_stat_type      stat
);

   localparam int CountWidth = $clog2(AccWidth);
   localparam logic [CountWidth-1:0] LastCount = CountWidth'(AccWidth - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [AccWidth-1:0]   quo_ff, quo_in;
   logic [CptWidth-1:0]   rem_ff, rem_in;
   logic [CptWidth-1:0]   dvs_ff, dvs_in;

   logic [CptWidth:0]     shifted;
   logic [CptWidth:0]     trial;

   // partial remainder shifted by one dividend bit, then trial subtract
   assign shifted = {rem_ff, quo_ff[AccWidth-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   // next state
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (cmd.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = cmd.dividend;
         rem_in   = '0;
         dvs_in   = cmd.divisor;
      end else if (busy_ff) begin
         // keep the difference only when it did not go negative
         if (!trial[CptWidth]) begin
            rem_in = trial[CptWidth-1:0];
            quo_in = {quo_ff[AccWidth-2:0], 1'b1};
         end else begin
            rem_in = shifted[CptWidth-1:0];
            quo_in = {quo_ff[AccWidth-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == LastCount) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   // status out
   assign stat.busy      = busy_ff;
   assign stat.done      = done_ff;
   assign stat.quotient  = quo_ff;
   assign stat.remainder = rem_ff;

endmodule

`default_nettype wire

### test/encoder_multiturn_tracker_top_tb.sv
// ----------------------------------------------------------------------------
// encoder_multiturn_tracker_top_tb
// self-checking bench for the multi-turn encoder tracker: a clocked driver
// feeds queued requests, a clocked monitor checks every result against a
// built-in tracking model, across absolute and incremental modes, clamped
// and extreme turn sizes, a long output stall and positions outside the turn
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_multiturn_tracker_top_tb import emt_pkg::*;;

   localparam int     PosBits       = 16;
   localparam longint MaxTurn       = longint'(1) << PosBits;
   localparam int     IdlePercent   = 11;
   localparam int     SteadyFrom    = 300;
   localparam int     SteadyTo      = 450;
   localparam int     HoldOffAt     = 120;
   localparam int     HoldOffCycles = 300;
   localparam int     SettleCycles  = 4;
   localparam int     DrainCycles   = 60;
   localparam int     FarPairs      = 20;

   typedef struct {
      logic                  kind;
      logic [ValueWidth-1:0] value;
   } angle_request_type;

   typedef struct {
      logic [PosOutWidth-1:0]       position;
      logic signed [AccWidth-1:0]   total_angle;
      logic signed [ValueWidth-1:0] last_step;
      logic signed [AccWidth-1:0]   turn_count;
   } track_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [CptWidth-1:0]    csr_wdata;

   emt_req_if req_if ();
   emt_rsp_if rsp_if ();

   encoder_multiturn_tracker_top #(
      .POSITION_BITS(PosBits)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #5 clock = ~clock;

   // tracking model state and its copy of the registers
   logic                   model_mode = ModeAbsolute;
   logic [CptWidth-1:0]    model_cpt  = CptReset;
   logic [PosOutWidth-1:0] last_pos   = '0;
   logic [AccWidth-1:0]    acc_angle  = '0;
   logic [ValueWidth-1:0]  step_reg   = '0;
   logic [AccWidth-1:0]    turn_ctr   = '0;

   angle_request_type angle_request_q[$];
   track_result_type  expected_track_q[$];

   int requests_queued = 0;
   int requests_taken  = 0;
   int results_seen    = 0;
   int mismatch_count  = 0;
   int settings_run    = 0;
   int hold_left       = 0;
   bit hold_done       = 1'b0;

   angle_request_type taken_req;
   angle_request_type next_req;
   track_result_type  want;

   // effective turn size after clamping to the supported range
   function automatic longint turn_size_of(input logic [CptWidth-1:0] cpt_val);
      longint ts;
      ts = cpt_val;
      if (ts < MinTurn) begin
         ts = MinTurn;
      end else if (ts > MaxTurn) begin
         ts = MaxTurn;
      end
      return ts;
   endfunction

   // advance the tracking model by one request and return its result
   function automatic track_result_type track_request(input angle_request_type rq);
      longint           ts, half, pos_new, pos_old, diff, step, acc, quot, rem;
      track_result_type res;
      ts = turn_size_of(model_cpt);
      if (rq.kind == KindPreset) begin
         // preset only matters for an absolute encoder
         if (model_mode == ModeAbsolute) begin
            last_pos = rq.value[PosOutWidth-1:0];
         end
      end else if (model_mode == ModeAbsolute) begin
         // unwrap across the half-turn boundary
         half    = ts / 2;
         pos_new = rq.value[PosOutWidth-1:0];
         pos_old = last_pos;
         diff    = pos_new - pos_old;
         if (diff > half) begin
            diff     = diff - ts;
            turn_ctr = turn_ctr - 1;
         end else if (diff < -half) begin
            diff     = diff + ts;
            turn_ctr = turn_ctr + 1;
         end
         last_pos  = rq.value[PosOutWidth-1:0];
         acc_angle = acc_angle + diff[AccWidth-1:0];
         step_reg  = diff[ValueWidth-1:0];
      end else begin
         // incremental: floored split of the accumulated angle
         step      = $signed(rq.value);
         acc_angle = acc_angle + step[AccWidth-1:0];
         step_reg  = step[ValueWidth-1:0];
         acc       = $signed(acc_angle);
         quot      = acc / ts;
         rem       = acc % ts;
         if (rem < 0) begin
            rem  = rem + ts;
            quot = quot - 1;
         end
         last_pos = rem[PosOutWidth-1:0];
         turn_ctr = quot[AccWidth-1:0];
      end
      res.position    = last_pos;
      res.total_angle = acc_angle;
      res.last_step   = step_reg;
      res.turn_count  = turn_ctr;
      return res;
   endfunction

   // random idle, switched off over a steady stretch
   function automatic bit idle_now(input int count);
      return (count < SteadyFrom || count >= SteadyTo) &&
             ($urandom_range(99) < IdlePercent);
   endfunction

   function automatic longint rand_between(input longint lo, input longint hi);
      return lo + longint'($urandom_range(32'(hi - lo)));
   endfunction

   task automatic push_request(input logic kind, input logic [ValueWidth-1:0] value);
      angle_request_type rq;
      rq.kind  = kind;
      rq.value = value;
      angle_request_q.push_back(rq);
      requests_queued++;
   endtask

   task automatic write_csr(input logic [CsrIdxWidth-1:0] idx,
                            input logic [CptWidth-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CsrIdxMode) begin
         model_mode = data[0];
      end else begin
         model_cpt = data;
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_tracker(input logic mode_sel, input logic [CptWidth-1:0] cpt_val);
      write_csr(CsrIdxMode, CptWidth'(mode_sel));
      write_csr(CsrIdxCpt, cpt_val);
      settings_run++;
   endtask

   // wait for every queued request to be taken and answered, then pause
   task automatic settle(input int pause);
      do @(posedge clock);
      while (requests_taken != requests_queued || expected_track_q.size() != 0);
      repeat (pause) @(posedge clock);
   endtask

   // mostly well-formed motion for the current turn size, some noise
   task automatic fill_random(input logic mode_sel, input logic [CptWidth-1:0] cpt_val,
                              input int n_items);
      longint                ts, half, cursor, delta, step;
      int                    pick;
      logic [ValueWidth-1:0] raw;
      ts     = turn_size_of(cpt_val);
      half   = ts / 2;
      cursor = rand_between(0, ts - 1);
      if (mode_sel == ModeAbsolute) begin
         push_request(KindPreset, ValueWidth'(cursor));
      end
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(99);
         raw  = ValueWidth'($urandom);
         if (mode_sel == ModeAbsolute) begin
            if (pick < 70) begin
               case ($urandom_range(3))
                  0: delta = rand_between(-half, half);
                  1: begin
                     // right on or just past the half turn
                     delta = half + longint'($urandom_range(1));
                     if ($urandom_range(1)) delta = -delta;
                  end
                  2: delta = rand_between(-8, 8);
                  default: delta = rand_between(1 - ts, ts - 1);
               endcase
               cursor = ((cursor + delta) % ts + ts) % ts;
               push_request(KindSample, ValueWidth'(cursor));
            end else if (pick < 80) begin
               cursor = rand_between(0, ts - 1);
               push_request(KindPreset, ValueWidth'(cursor));
            end else begin
               // any bit pattern, in or out of the turn
               push_request(pick < 90 ? KindSample : KindPreset, raw);
               cursor = raw[PosOutWidth-1:0];
               cursor = cursor % ts;
            end
         end else begin
            if (pick < 85) begin
               if (pick < 75) begin
                  step = rand_between(-2 * ts, 2 * ts);
               end else begin
                  case ($urandom_range(3))
                     0: step = ts;
                     1: step = -ts;
                     2: step = $urandom_range(1) ? 1 : -1;
                     default: step = 0;
                  endcase
               end
               if (step > 65535) step = 65535;
               else if (step < -65536) step = -65536;
               push_request(KindSample, ValueWidth'(step));
            end else begin
               push_request(pick < 95 ? KindSample : KindPreset, raw);
            end
         end
      end
   endtask

   task automatic run_phase(input logic mode_sel, input logic [CptWidth-1:0] cpt_val,
                            input int n_items);
      set_tracker(mode_sel, cpt_val);
      fill_random(mode_sel, cpt_val, n_items);
      settle(SettleCycles);
   endtask

   // request driver: predict on acceptance, then offer the next request
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) begin
            taken_req.kind  = req_if.kind;
            taken_req.value = req_if.angle_value;
            expected_track_q.push_back(track_request(taken_req));
            requests_taken++;
         end
         if (angle_request_q.size() != 0 && !idle_now(requests_taken)) begin
            next_req = angle_request_q.pop_front();
            req_if.valid       <= 1'b1;
            req_if.kind        <= next_req.kind;
            req_if.angle_value <= next_req.value;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result monitor with random stalls and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (expected_track_q.size() == 0) begin
               $error("result with no request outstanding");
               mismatch_count++;
            end else begin
               want = expected_track_q.pop_front();
               if (rsp_if.position !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position, rsp_if.position);
                  mismatch_count++;
               end
               if (rsp_if.total_angle !== want.total_angle) begin
                  $error("total_angle: expected %0d, got %0d",
                         want.total_angle, rsp_if.total_angle);
                  mismatch_count++;
               end
               if (rsp_if.last_step !== want.last_step) begin
                  $error("last_step: expected %0d, got %0d", want.last_step, rsp_if.last_step);
                  mismatch_count++;
               end
               if (rsp_if.turn_count !== want.turn_count) begin
                  $error("turn_count: expected %0d, got %0d",
                         want.turn_count, rsp_if.turn_count);
                  mismatch_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (!hold_done && results_seen == HoldOffAt) begin
            hold_done = 1'b1;
            hold_left = HoldOffCycles - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= !idle_now(results_seen);
         end
      end
   end

   // stimulus and end of run
   initial begin
      csr_we             = 1'b0;
      csr_index          = CsrIdxMode;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.kind        = KindSample;
      req_if.angle_value = '0;
      rsp_if.ready       = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // absolute mode at reset settings: half-turn edges, wraps, presets,
      // positions with the top field bit set
      push_request(KindSample, 17'd0);
      push_request(KindSample, 17'd100);
      push_request(KindSample, 17'd4196);
      push_request(KindSample, 17'd100);
      push_request(KindSample, 17'd4197);
      push_request(KindSample, 17'd8191);
      push_request(KindSample, 17'd0);
      push_request(KindPreset, 17'd5000);
      push_request(KindSample, 17'd5000);
      push_request(KindSample, 17'h1FFFF);
      push_request(KindSample, 17'h10000);
      push_request(KindPreset, 17'h1FFFF);
      push_request(KindSample, 17'd0);
      push_request(KindSample, 17'h0FFFF);
      settle(SettleCycles);

      // incremental mode, turn size still at reset: extreme steps, preset ignored
      write_csr(CsrIdxMode, CptWidth'(ModeIncremental));
      push_request(KindSample, 17'h0FFFF);
      push_request(KindSample, 17'h18000);
      push_request(KindSample, 17'h10000);
      push_request(KindPreset, 17'd123);
      push_request(KindSample, 17'd0);
      push_request(KindSample, 17'h1FFFF);
      push_request(KindSample, 17'd1);
      settle(SettleCycles);

      // random motion over a spread of settings, clamped sizes included
      run_phase(ModeAbsolute,    17'd8192,   70);
      run_phase(ModeIncremental, 17'd8192,   55);
      run_phase(ModeAbsolute,    17'd2,      50);
      run_phase(ModeIncremental, 17'd2,      50);
      run_phase(ModeAbsolute,    17'h10000,  65);
      run_phase(ModeIncremental, 17'h10000,  55);
      run_phase(ModeAbsolute,    17'd0,      40);
      run_phase(ModeIncremental, 17'h1FFFF,  50);
      run_phase(ModeAbsolute,    17'd3,      50);
      run_phase(ModeIncremental, 17'd1,      40);
      run_phase(ModeAbsolute,    17'h10001,  50);
      run_phase(ModeIncremental, CptWidth'($urandom_range(65536, 2)), 50);
      run_phase(ModeAbsolute,    CptWidth'($urandom_range(65536, 2)), 55);

      // positions far outside a two-count turn: the adjusted step stays large
      set_tracker(ModeAbsolute, 17'd2);
      for (int i = 0; i < FarPairs; i++) begin
         push_request(KindPreset, 17'd0);
         push_request(KindSample, 17'h0FFFF);
      end
      settle(SettleCycles);

      // floored split on whole turns of the largest size, then a small turn
      set_tracker(ModeIncremental, 17'h10000);
      repeat (40) push_request(KindSample, 17'h10000);
      fill_random(ModeIncremental, 17'h10000, 30);
      settle(SettleCycles);
      run_phase(ModeIncremental, 17'd5, 30);

      settle(DrainCycles);
      $display("covered %0d requests over %0d tracker settings, incl. far-off positions",
               requests_taken, settings_run);
      $display("checked %0d results, %0d mismatches", results_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20000000;
      $display("timeout with %0d results outstanding", expected_track_q.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
